### rtl/dtrc_pkg.sv
// Shared types and constants for the decimal trie rank counter.
// Used by the controller, the datapath and the top level.
`timescale 1ns / 1ps

package dtrc_pkg;

   localparam int NODE_POOL_DEF  = 4096;
   localparam int KEY_DIGITS_DEF = 20;
   localparam int TOTAL_DIGITS   = 20;
   localparam int RADIX          = 10;
   localparam int DIGIT_W        = 4;
   localparam int POS_W          = 5;
   localparam int SLOT_W         = 4;
   localparam int COUNT_W        = 32;

   typedef enum logic [1:0] {
      ST_OK        = 2'd0,
      ST_BAD_PRIO  = 2'd1,
      ST_POOL_FULL = 2'd2,
      ST_BAD_DIGIT = 2'd3
   } status_type;

   typedef enum logic {
      CMD_INSERT = 1'b0,
      CMD_QUERY  = 1'b1
   } command_type;

   typedef enum logic [3:0] {
      S_IDLE,
      S_CLEAR,
      S_CHECK,
      S_PLAN_RD,
      S_PLAN_WAIT,
      S_PLAN_STEP,
      S_INS_RD,
      S_INS_WAIT,
      S_INS_STEP,
      S_INS_CNT,
      S_Q_RD,
      S_Q_WAIT,
      S_Q_STEP,
      S_Q_CNT,
      S_Q_DESC,
      S_DONE
   } state_type;

   // controller -> datapath
   typedef struct packed {
      logic clear_step;
      logic load;
      logic start_walk;
      logic slot_reset;
      logic rd_child;
      logic plan_step;
      logic ins_step;
      logic cnt_write;
      logic q_add;
      logic slot_next;
      logic descend;
      logic pos_next;
   } cmd_type;

   // datapath -> controller
   typedef struct packed {
      logic        clear_done;
      logic        bad_digit;
      logic        bad_prio;
      logic        is_query;
      logic        last_pos;
      logic        child_zero;
      logic        pool_full;
      logic        slot_is_key;
   } stat_type;

endpackage

### rtl/dtrc_ctrl.sv
// Sequencing controller of the trie rank counter.
// Depends on dtrc_pkg for the state, command and status types.
`timescale 1ns / 1ps

module dtrc_ctrl (
   input  logic                 clock,
   input  logic                 reset,
   input  logic                 req_valid,
   output logic                 req_stall,
   output logic                 rsp_valid,
   input  logic                 rsp_stall,
   input  dtrc_pkg::stat_type   stat,
   output dtrc_pkg::cmd_type    cmd
);

   dtrc_pkg::state_type state_ff, state_in;

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff <= dtrc_pkg::S_CLEAR;
      end else begin
         state_ff <= state_in;
      end
   end

   always_comb begin
      state_in = state_ff;
      case (state_ff)
         dtrc_pkg::S_CLEAR: begin
            if (stat.clear_done) state_in = dtrc_pkg::S_IDLE;
         end
         dtrc_pkg::S_IDLE: begin
            if (req_valid) state_in = dtrc_pkg::S_CHECK;
         end
         dtrc_pkg::S_CHECK: begin
            if (stat.bad_digit || (stat.is_query && stat.bad_prio)) begin
               state_in = dtrc_pkg::S_DONE;
            end else if (stat.is_query) begin
               state_in = dtrc_pkg::S_Q_RD;
            end else begin
               state_in = dtrc_pkg::S_PLAN_RD;
            end
         end
         dtrc_pkg::S_PLAN_RD:   state_in = dtrc_pkg::S_PLAN_WAIT;
         dtrc_pkg::S_PLAN_WAIT: state_in = dtrc_pkg::S_PLAN_STEP;
         dtrc_pkg::S_PLAN_STEP: begin
            if (stat.last_pos) begin
               state_in = stat.pool_full ? dtrc_pkg::S_DONE : dtrc_pkg::S_INS_RD;
            end else begin
               state_in = dtrc_pkg::S_PLAN_RD;
            end
         end
         dtrc_pkg::S_INS_RD:   state_in = dtrc_pkg::S_INS_WAIT;
         dtrc_pkg::S_INS_WAIT: state_in = dtrc_pkg::S_INS_STEP;
         dtrc_pkg::S_INS_STEP: state_in = dtrc_pkg::S_INS_CNT;
         dtrc_pkg::S_INS_CNT: begin
            state_in = stat.last_pos ? dtrc_pkg::S_DONE : dtrc_pkg::S_INS_RD;
         end
         dtrc_pkg::S_Q_RD:   state_in = dtrc_pkg::S_Q_WAIT;
         dtrc_pkg::S_Q_WAIT: state_in = dtrc_pkg::S_Q_STEP;
         dtrc_pkg::S_Q_STEP: begin
            if (stat.slot_is_key) begin
               state_in = dtrc_pkg::S_Q_DESC;
            end else begin
               state_in = dtrc_pkg::S_Q_CNT;
            end
         end
         dtrc_pkg::S_Q_CNT: state_in = dtrc_pkg::S_Q_RD;
         dtrc_pkg::S_Q_DESC: begin
            if (stat.child_zero || stat.last_pos) begin
               state_in = dtrc_pkg::S_DONE;
            end else begin
               state_in = dtrc_pkg::S_Q_RD;
            end
         end
         dtrc_pkg::S_DONE: begin
            if (!rsp_stall) state_in = dtrc_pkg::S_IDLE;
         end
         default: state_in = dtrc_pkg::S_CLEAR;
      endcase
   end

   always_comb begin
      cmd       = '0;
      req_stall = 1'b1;
      rsp_valid = 1'b0;
      case (state_ff)
         dtrc_pkg::S_CLEAR: cmd.clear_step = 1'b1;
         dtrc_pkg::S_IDLE: begin
            req_stall = 1'b0;
            cmd.load  = 1'b1;
         end
         dtrc_pkg::S_CHECK: begin
            cmd.start_walk = 1'b1;
            cmd.slot_reset = 1'b1;
         end
         dtrc_pkg::S_PLAN_RD, dtrc_pkg::S_INS_RD, dtrc_pkg::S_Q_RD: cmd.rd_child = 1'b1;
         // the datapath rewinds the walk itself after the last planning level
         dtrc_pkg::S_PLAN_STEP: cmd.plan_step = 1'b1;
         dtrc_pkg::S_INS_STEP: cmd.ins_step = 1'b1;
         dtrc_pkg::S_INS_CNT: begin
            cmd.cnt_write = 1'b1;
            cmd.pos_next  = 1'b1;
         end
         dtrc_pkg::S_Q_CNT: begin
            cmd.q_add     = 1'b1;
            cmd.slot_next = 1'b1;
         end
         dtrc_pkg::S_Q_DESC: begin
            cmd.descend    = 1'b1;
            cmd.pos_next   = 1'b1;
            cmd.slot_reset = 1'b1;
         end
         dtrc_pkg::S_DONE: rsp_valid = 1'b1;
         default: ;
      endcase
   end

endmodule

### rtl/dtrc_datapath.sv
// Datapath of the trie rank counter: child and count memories, walk registers.
// Depends on dtrc_pkg; driven by dtrc_ctrl through cmd_type/stat_type.
`timescale 1ns / 1ps

module dtrc_datapath #(
   parameter int NODE_POOL  = dtrc_pkg::NODE_POOL_DEF,
   parameter int KEY_DIGITS = dtrc_pkg::KEY_DIGITS_DEF,
   localparam int NODE_W    = $clog2(NODE_POOL),
   localparam int CHILD_DEPTH = NODE_POOL * dtrc_pkg::RADIX,
   localparam int CADDR_W   = $clog2(CHILD_DEPTH)
) (
   input  logic                    clock,
   input  logic                    reset,
   input  logic                    req_command,
   input  logic [39:0]             req_key_upper_bcd,
   input  logic [39:0]             req_key_lower_bcd,
   input  logic [39:0]             req_priority_order,
   output logic [31:0]             rsp_rank,
   output logic [1:0]              rsp_status,
   input  dtrc_pkg::cmd_type       cmd,
   output dtrc_pkg::stat_type      stat
);

   localparam int START_POS = dtrc_pkg::TOTAL_DIGITS - KEY_DIGITS;
   localparam logic [NODE_W-1:0] NODE_MAX = NODE_W'(NODE_POOL - 1);

   logic [NODE_W-1:0] child_mem [CHILD_DEPTH];
   logic [31:0]       count_mem [NODE_POOL];

   logic                 command_ff;
   logic [79:0]          key_ff;
   logic [39:0]          prio_ff;
   logic [4:0]           pos_ff;
   logic [NODE_W-1:0]    cur_ff;
   logic [NODE_W-1:0]    used_ff;
   logic [NODE_W:0]      need_ff;
   logic                 off_ff;
   logic [3:0]           slot_ff;
   logic [31:0]          acc_ff;
   logic [1:0]           status_ff;
   logic [NODE_W-1:0]    rd_child_ff;
   logic [31:0]          rd_count_ff;
   logic [CADDR_W:0]     clr_ff;

   logic [3:0] key_digit, order_digit, sel_digit;
   logic       bad_digit, bad_prio;
   logic [CADDR_W-1:0] caddr;
   logic [NODE_W-1:0]  new_node;

   always_comb begin
      logic [dtrc_pkg::RADIX-1:0] seen;
      logic [3:0] p;
      bad_digit = 1'b0;
      for (int i = START_POS; i < dtrc_pkg::TOTAL_DIGITS; i++) begin
         if (key_ff[79-4*i -: 4] > 4'd9) bad_digit = 1'b1;
      end
      seen     = '0;
      bad_prio = 1'b0;
      for (int i = 0; i < dtrc_pkg::RADIX; i++) begin
         p = prio_ff[39-4*i -: 4];
         if (p > 4'd9) begin
            bad_prio = 1'b1;
         end else begin
            if (seen[p]) bad_prio = 1'b1;
            seen[p] = 1'b1;
         end
      end
   end

   assign key_digit   = key_ff[79 - 4*pos_ff -: 4];
   assign order_digit = prio_ff[39 - 4*slot_ff -: 4];
   assign sel_digit   = command_ff ? order_digit : key_digit;
   assign caddr = CADDR_W'(cur_ff) * CADDR_W'(dtrc_pkg::RADIX) + CADDR_W'(sel_digit);
   assign new_node = used_ff + NODE_W'(1);

   // memory ports: one write and one registered read per cycle each
   always_ff @(posedge clock) begin
      if (cmd.clear_step && clr_ff < (CADDR_W+1)'(CHILD_DEPTH)) begin
         child_mem[clr_ff[CADDR_W-1:0]] <= '0;
      end else if (cmd.ins_step && rd_child_ff == '0) begin
         child_mem[caddr] <= new_node;
      end
      if (cmd.rd_child) rd_child_ff <= child_mem[caddr];
   end

   logic [NODE_W-1:0] count_addr;
   assign count_addr = rd_child_ff;

   always_ff @(posedge clock) begin
      if (cmd.clear_step && clr_ff < (CADDR_W+1)'(NODE_POOL)) begin
         count_mem[clr_ff[NODE_W-1:0]] <= '0;
      end else if (cmd.cnt_write && rd_count_ff != '1) begin
         count_mem[cur_ff] <= rd_count_ff + 32'd1;
      end
      rd_count_ff <= count_mem[(cmd.ins_step && rd_child_ff == '0) ? new_node : count_addr];
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         clr_ff  <= '0;
         used_ff <= '0;
      end else begin
         if (cmd.clear_step) clr_ff <= clr_ff + (CADDR_W+1)'(1);
         if (cmd.ins_step && rd_child_ff == '0) used_ff <= new_node;
      end
   end

   always_ff @(posedge clock) begin
      if (cmd.load) begin
         command_ff <= req_command;
         key_ff     <= {req_key_upper_bcd, req_key_lower_bcd};
         prio_ff    <= req_priority_order;
         acc_ff     <= '0;
         status_ff  <= dtrc_pkg::ST_OK;
      end
      if (cmd.slot_reset) slot_ff <= '0;
      else if (cmd.slot_next) slot_ff <= slot_ff + 4'd1;
      if (cmd.q_add && rd_child_ff != '0) begin
         acc_ff <= (acc_ff + rd_count_ff < acc_ff) ? '1 : acc_ff + rd_count_ff;
      end
      if (cmd.start_walk) begin
         pos_ff  <= 5'(START_POS);
         cur_ff  <= '0;
         need_ff <= '0;
         off_ff  <= 1'b0;
         if (bad_digit) status_ff <= dtrc_pkg::ST_BAD_DIGIT;
         else if (command_ff && bad_prio) status_ff <= dtrc_pkg::ST_BAD_PRIO;
      end else if (cmd.plan_step) begin
         if (stat.last_pos) begin
            // rewind for the update walk
            pos_ff <= 5'(START_POS);
            cur_ff <= '0;
            if (stat.pool_full) status_ff <= dtrc_pkg::ST_POOL_FULL;
         end else begin
            pos_ff <= pos_ff + 5'd1;
            if (off_ff || rd_child_ff == '0) begin
               off_ff  <= 1'b1;
               need_ff <= need_ff + (NODE_W+1)'(1);
            end else begin
               cur_ff <= rd_child_ff;
            end
         end
      end else begin
         if (cmd.ins_step) cur_ff <= (rd_child_ff == '0) ? new_node : rd_child_ff;
         else if (cmd.descend) cur_ff <= rd_child_ff;
         if (cmd.pos_next) pos_ff <= pos_ff + 5'd1;
      end
   end

   logic [NODE_W:0] need_total;
   assign need_total = need_ff + {{NODE_W{1'b0}}, (off_ff || rd_child_ff == '0)};

   always_comb begin
      stat             = '0;
      stat.clear_done  = (clr_ff >= (CADDR_W+1)'(CHILD_DEPTH));
      stat.bad_digit   = bad_digit;
      stat.bad_prio    = bad_prio;
      stat.is_query    = command_ff;
      stat.last_pos    = (pos_ff == 5'(dtrc_pkg::TOTAL_DIGITS - 1));
      stat.child_zero  = (rd_child_ff == '0);
      stat.pool_full   = ({1'b0, used_ff} + need_total > {1'b0, NODE_MAX});
      stat.slot_is_key = (order_digit == key_digit);
   end

   assign rsp_status = status_ff;
   assign rsp_rank   = (status_ff == dtrc_pkg::ST_OK) ? acc_ff : '0;

endmodule

### rtl/digit_trie_rank_counter.sv
// Top level of the decimal trie rank counter.
// Depends on dtrc_pkg, dtrc_ctrl and dtrc_datapath.
`timescale 1ns / 1ps

// Stores 20-digit BCD keys in a 10-way trie and answers rank queries under a
// digit priority order. One request at a time: an insert makes a planning walk
// and an update walk, each a registered child memory read per key digit; a
// query visits priority slots in order at each level, the key digit's own slot
// included, with a registered child memory read per slot visited. The child
// memory has a single read port. After reset a clearing pass over the child
// and count memories runs before the first request is taken.
module digit_trie_rank_counter #(
   parameter int NODE_POOL  = dtrc_pkg::NODE_POOL_DEF,
   parameter int KEY_DIGITS = dtrc_pkg::KEY_DIGITS_DEF
) (
   input  logic        clock,
   input  logic        reset,
   input  logic        req_valid,
   output logic        req_stall,
   input  logic        req_command,
   input  logic [39:0] req_key_upper_bcd,
   input  logic [39:0] req_key_lower_bcd,
   input  logic [39:0] req_priority_order,
   output logic        rsp_valid,
   input  logic        rsp_stall,
   output logic [31:0] rsp_rank,
   output logic [1:0]  rsp_status
);

   dtrc_pkg::cmd_type  cmd;
   dtrc_pkg::stat_type stat;

   dtrc_ctrl u_ctrl (
      .clock(clock), .reset(reset),
      .req_valid(req_valid), .req_stall(req_stall),
      .rsp_valid(rsp_valid), .rsp_stall(rsp_stall),
      .stat(stat), .cmd(cmd)
   );

   dtrc_datapath #(.NODE_POOL(NODE_POOL), .KEY_DIGITS(KEY_DIGITS)) u_dp (
      .clock(clock), .reset(reset),
      .req_command(req_command),
      .req_key_upper_bcd(req_key_upper_bcd),
      .req_key_lower_bcd(req_key_lower_bcd),
      .req_priority_order(req_priority_order),
      .rsp_rank(rsp_rank), .rsp_status(rsp_status),
      .cmd(cmd), .stat(stat)
   );

`ifndef SYNTH
   a_no_overlap: assert property (@(posedge clock) disable iff (reset)
      !(rsp_valid && !req_stall)) else $error("input taken while beat pending");
   a_refused_zero: assert property (@(posedge clock) disable iff (reset)
      rsp_valid && rsp_status != dtrc_pkg::ST_OK |-> rsp_rank == '0)
      else $error("refused beat carries a rank");
   a_rsp_after_req: assert property (@(posedge clock) disable iff (reset)
      req_valid && !req_stall |=> !rsp_valid) else $error("result too early");
`endif

endmodule
